/* src/ppsc_pkg.sv */
// ppsc_pkg: shared widths and limits for the positive pair sum counter
// no dependencies; used by positive_pair_sum_counter_core
`timescale 1ns / 1ps

package ppsc_pkg;

  // width of the pair_count result field
  localparam int unsigned PAIR_COUNT_W = 19;

  // saturation value of the pair count
  localparam logic [PAIR_COUNT_W-1:0] COUNT_MAX = {PAIR_COUNT_W{1'b1}};

endpackage

/* src/ppsc_ram.sv */
// ppsc_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ppsc_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/positive_pair_sum_counter_core.sv */
// positive_pair_sum_counter_core: collects pair differences and counts positive pair sums
// depends on ppsc_pkg and ppsc_ram
`timescale 1ns / 1ps

// Usage:
//  The input channel (in_valid_i / in_stall_o) carries one word per pair of values.
//  Each accepted word stores first minus second in a difference ram;
//  words beyond MAX_ITEMS are dropped and flag overflow on the set's result.
//  A word with last_item_i set closes the set and starts the count. The input then
//  stalls while one shared adder and compare walks every stored pair i < j,
//  reading one difference a cycle from the ram's single read port.
//  For n stored differences the count makes n-1 outer passes, each a reload of
//  d[i] (S_RD_I, S_LAT_I), n-1-i reads of d[j] and a drain of the last read.
//  Sets of fewer than two differences skip the count and go to S_FINISH.
//  The result word (pair_count_o, overflow_o) sits in an output register on
//  out_valid_o. Words of the next set are accepted while it waits; if a second
//  result is ready before the first is taken, the core holds it and stalls input
//  until the receiver lowers out_stall_i.
//  Reset empties the set, clears the overflow flag and drops any pending result.
//  The ram content is not cleared; only entries of the current set are read.
module positive_pair_sum_counter_core #(
  parameter int unsigned MAX_ITEMS  = 1024,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [VALUE_BITS-1:0]             first_value_i,
  input  logic [VALUE_BITS-1:0]             second_value_i,
  input  logic                              last_item_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ppsc_pkg::PAIR_COUNT_W-1:0] pair_count_o,
  output logic                              overflow_o
);

  localparam int unsigned ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned DIFF_W = VALUE_BITS + 1;
  localparam int unsigned SUM_W  = VALUE_BITS + 2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_I   = 3'd1;
  localparam logic [2:0] S_LAT_I  = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  item_cnt_q, item_cnt_d;
  logic              drop_q, drop_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic              issued_q, issued_d;
  logic [ppsc_pkg::PAIR_COUNT_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              drop_res_q, drop_res_d;
  logic [ppsc_pkg::PAIR_COUNT_W-1:0] pair_count_q, pair_count_d;
  logic              overflow_q, overflow_d;
  logic signed [DIFF_W-1:0] di_q, di_d;

  logic              in_acc;
  logic              store_ok;
  logic [CNT_W-1:0]  item_cnt_inc;
  logic signed [DIFF_W-1:0] diff;
  logic [ADDR_W-1:0] raddr;
  logic signed [DIFF_W-1:0] rdata;
  logic signed [SUM_W-1:0]  pair_sum;
  logic              out_free;
  logic              outer_done;

  // input handshake: only open between sets
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store_ok   = (item_cnt_q < CNT_W'(MAX_ITEMS));
  assign item_cnt_inc = item_cnt_q + CNT_W'(1);

  // difference of the two values, one bit wider and signed
  assign diff = $signed({1'b0, first_value_i}) - $signed({1'b0, second_value_i});

  // read address: d[i] on reload, d[j] during the sweep
  assign raddr = (state_q == S_RD_I) ? i_q[ADDR_W-1:0] : j_q[ADDR_W-1:0];

  ppsc_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (MAX_ITEMS)
  ) u_diff_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && store_ok),
    .waddr_i (item_cnt_q[ADDR_W-1:0]),
    .wdata_i (diff),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared adder and compare
  assign pair_sum = SUM_W'(di_q) + SUM_W'(rdata);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign outer_done = ({1'b0, i_q} + (CNT_W + 1)'(2)) >= {1'b0, n_q};

  // sequencer
  always_comb begin
    state_d      = state_q;
    item_cnt_d   = item_cnt_q;
    drop_d       = drop_q;
    n_d          = n_q;
    i_d          = i_q;
    j_d          = j_q;
    issued_d     = 1'b0;
    cnt_d        = cnt_q;
    drop_res_d   = drop_res_q;
    di_d         = di_q;
    out_valid_d  = out_valid_q && out_stall_i;
    pair_count_d = pair_count_q;
    overflow_d   = overflow_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (store_ok) begin
            item_cnt_d = item_cnt_inc;
          end else begin
            drop_d = 1'b1;
          end
          if (last_item_i) begin
            n_d        = store_ok ? item_cnt_inc : item_cnt_q;
            drop_res_d = drop_q || !store_ok;
            item_cnt_d = '0;
            drop_d     = 1'b0;
            cnt_d      = '0;
            i_d        = '0;
            if (store_ok ? (item_cnt_inc >= CNT_W'(2)) : (item_cnt_q >= CNT_W'(2))) begin
              state_d = S_RD_I;
            end else begin
              state_d = S_FINISH;
            end
          end
        end
      end
      S_RD_I: begin
        j_d     = i_q + CNT_W'(1);
        state_d = S_LAT_I;
      end
      S_LAT_I: begin
        di_d    = rdata;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        // count the word read in the previous cycle
        if (issued_q && (pair_sum > 0) && (cnt_q != ppsc_pkg::COUNT_MAX)) begin
          cnt_d = cnt_q + ppsc_pkg::PAIR_COUNT_W'(1);
        end
        if (j_q < n_q) begin
          j_d      = j_q + CNT_W'(1);
          issued_d = 1'b1;
        end else if (!issued_q) begin
          if (outer_done) begin
            state_d = S_FINISH;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = S_RD_I;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          pair_count_d = cnt_q;
          overflow_d   = drop_res_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_cnt_q  <= '0;
      drop_q      <= 1'b0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      issued_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      item_cnt_q  <= item_cnt_d;
      drop_q      <= drop_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      issued_q    <= issued_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    di_q         <= di_d;
    drop_res_q   <= drop_res_d;
    pair_count_q <= pair_count_d;
    overflow_q   <= overflow_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pair_count_o = pair_count_q;
  assign overflow_o   = overflow_q;

endmodule

/* test/testbench.sv */
// testbench: drives pair sets through positive_pair_sum_counter_core and checks every count
// depends on ppsc_pkg and the core; holds its own scoreboard that predicts each result word
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned STORE_DEPTH   = 1024;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned RANDOM_WORDS  = 200;
  localparam int unsigned CALM_FROM     = 150;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;

  typedef logic [VALUE_W-1:0] value_t;

  typedef struct {
    logic [ppsc_pkg::PAIR_COUNT_W-1:0] pair_count;
    logic                              overflow;
  } count_result_t;

  // shape of the values within one random set
  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_NEAR_ZERO,
    SPREAD_EXTREME,
    SPREAD_POSITIVE,
    SPREAD_NEGATIVE
  } spread_e;

  // scoreboard: keeps the current set and the counts still owed by the core
  class pair_count_board;
    int            diffs[STORE_DEPTH];
    int unsigned   stored;
    bit            dropped;
    count_result_t awaited[$];
    int unsigned   errors;

    function new();
      stored  = 0;
      dropped = 1'b0;
      errors  = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // store the difference, or drop it once the store is full; a last word closes the set
    function void note_word(value_t first, value_t second, logic last);
      int unsigned   total;
      int unsigned   i;
      int unsigned   j;
      count_result_t res;
      if (stored < STORE_DEPTH) begin
        diffs[stored] = int'({1'b0, first}) - int'({1'b0, second});
        stored++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        // the count does not depend on order, so every pair i < j is tried directly
        total = 0;
        for (i = 0; i < stored; i++) begin
          for (j = i + 1; j < stored; j++) begin
            if (diffs[i] + diffs[j] > 0) total++;
          end
        end
        if (total > ppsc_pkg::COUNT_MAX) total = ppsc_pkg::COUNT_MAX;
        res.pair_count = total[ppsc_pkg::PAIR_COUNT_W-1:0];
        res.overflow   = dropped;
        awaited.push_back(res);
        stored  = 0;
        dropped = 1'b0;
      end
    endfunction

    // compare one result word with the oldest owed count
    function void check_result(logic [ppsc_pkg::PAIR_COUNT_W-1:0] pair_count, logic overflow);
      count_result_t want;
      if (awaited.size() == 0) begin
        $error("result word with none owed: pair_count %0d overflow %0d", pair_count, overflow);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (pair_count !== want.pair_count) begin
        $error("pair_count: expected %0d, actual %0d", want.pair_count, pair_count);
        errors++;
      end
      if (overflow !== want.overflow) begin
        $error("overflow: expected %0d, actual %0d", want.overflow, overflow);
        errors++;
      end
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  value_t                            first_value_i;
  value_t                            second_value_i;
  logic                              last_item_i;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [ppsc_pkg::PAIR_COUNT_W-1:0] pair_count_o;
  logic                              overflow_o;

  pair_count_board board;
  bit              calm = 1'b0;
  int unsigned     cycle_count = 0;
  int unsigned     stall_left = 0;
  int unsigned     flow_left = 0;

  positive_pair_sum_counter_core #(
    .MAX_ITEMS  (STORE_DEPTH),
    .VALUE_BITS (VALUE_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pair_count_o   (pair_count_o),
    .overflow_o     (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: check taken words, then stall in bursts unless the run is calm
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(pair_count_o, overflow_o);
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (flow_left != 0) begin
      flow_left--;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      flow_left  = $urandom_range(0, 40);
      stall_left = $urandom_range(1, 10);
      out_stall_i <= 1'b0;
    end
  end

  // optional idle burst, then one word held until the core takes it
  task automatic offer_word(value_t first, value_t second, logic last);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    first_value_i  <= first;
    second_value_i <= second;
    last_item_i    <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_word(first, second, last);
  endtask

  function automatic value_t extreme_value();
    unique case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      3:       return 16'hFFFE;
      default: return 16'h8000;
    endcase
  endfunction

  // one complete set of the given size, closed by its last word
  task automatic send_set(int unsigned size, spread_e spread);
    value_t      base;
    value_t      first;
    value_t      second;
    int unsigned k;
    base = value_t'($urandom);
    for (k = 0; k < size; k++) begin
      unique case (spread)
        SPREAD_NEAR_ZERO: begin
          first  = base + value_t'($urandom_range(0, 6));
          second = base + value_t'($urandom_range(0, 6));
        end
        SPREAD_EXTREME: begin
          first  = extreme_value();
          second = extreme_value();
        end
        SPREAD_POSITIVE: begin
          first  = value_t'($urandom_range(32768, 65535));
          second = value_t'($urandom);
        end
        SPREAD_NEGATIVE: begin
          first  = value_t'($urandom);
          second = value_t'($urandom_range(32768, 65535));
        end
        default: begin
          first  = value_t'($urandom);
          second = value_t'($urandom);
        end
      endcase
      offer_word(first, second, k == size - 1);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned size;
    int unsigned pick;
    bit          paused;
    board = new();
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    first_value_i  <= '0;
    second_value_i <= '0;
    last_item_i    <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone words close sets of one
    offer_word(16'hFFFF, 16'h0000, 1'b1);
    offer_word(16'h0000, 16'hFFFF, 1'b1);
    // opposite extremes sum to zero, which is not counted
    offer_word(16'hFFFF, 16'h0000, 1'b0);
    offer_word(16'h0000, 16'hFFFF, 1'b1);
    // just above zero
    offer_word(16'hFFFF, 16'h0000, 1'b0);
    offer_word(16'h0001, 16'hFFFF, 1'b1);
    // all differences zero
    offer_word(16'h0000, 16'h0000, 1'b0);
    offer_word(16'h1234, 16'h1234, 1'b1);
    // mixed signs
    offer_word(16'd5, 16'd3, 1'b0);
    offer_word(16'd3, 16'd5, 1'b0);
    offer_word(16'd2, 16'd0, 1'b1);
    // every difference negative
    offer_word(16'h0000, 16'hFFFF, 1'b0);
    offer_word(16'd7, 16'd8, 1'b0);
    offer_word(16'd100, 16'd30000, 1'b1);
    // alternating bit patterns and a wide spread
    offer_word(16'hAAAA, 16'h5555, 1'b0);
    offer_word(16'h5555, 16'hAAAA, 1'b0);
    offer_word(16'd40000, 16'd100, 1'b0);
    offer_word(16'hFFFF, 16'hFFFF, 1'b1);

    // random sets, mostly short, a few longer
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      size = 1;
      else if (pick < 20) size = 2;
      else if (pick < 85) size = $urandom_range(3, 24);
      else                size = $urandom_range(25, 80);
      if (sent >= CALM_FROM) calm = 1'b1;
      send_set(size, spread_e'($urandom_range(0, 4)));
      sent += size;
      // sender holds off once until every owed count is back
      if (!paused && sent >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (board.pending() != 0);
      end
    end

    // full store: the last two words are dropped, the second of them closing the set
    calm = 1'b1;
    send_set(STORE_DEPTH + 2, SPREAD_FULL);
    // the next set starts clean again
    send_set(2, SPREAD_EXTREME);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
